/* rtl/utq_pkg.sv */
package utq_pkg;

  localparam int EVENT_TYPES = 16;
  localparam int TIME_W      = 64;
  localparam int TYPE_W      = 4;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POLL   = 2'd2,
    FUNC_REBASE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_SET,
    OP_CLEAR,
    OP_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LAUNCH,
    ST_SCAN
  } state_e;

  // Broadcast command to every cell
  typedef struct packed {
    cell_op_e            op;
    logic [TIME_W-1:0]   value;
  } cell_cmd_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic                token;
    logic                found;
    logic [TIME_W-1:0]   best_time;
  } scan_t;

endpackage

/* rtl/utq_cell.sv */
module utq_cell #(
  parameter int Idx  = 0,
  parameter int IdxW = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utq_pkg::cell_cmd_t    cmd_i,
  input  logic [IdxW-1:0]       sel_idx_i,
  input  utq_pkg::scan_t        scan_i,
  input  logic [IdxW-1:0]       scan_idx_i,
  output utq_pkg::scan_t        scan_o,
  output logic [IdxW-1:0]       scan_idx_o
);

  logic                          pending_q;
  logic [utq_pkg::TIME_W-1:0]    due_q;
  logic                          sel;
  logic                          hit;
  utq_pkg::scan_t                scan_d, scan_q;
  logic [IdxW-1:0]               scan_idx_d, scan_idx_q;

  assign sel = (sel_idx_i == IdxW'(Idx));

  // Storage: one pending mark and one due time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
    end else if (sel && cmd_i.op == utq_pkg::OP_SET) begin
      pending_q <= 1'b1;
    end else if (sel && cmd_i.op == utq_pkg::OP_CLEAR) begin
      pending_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && cmd_i.op == utq_pkg::OP_SET) begin
      due_q <= cmd_i.value;
    end else if (pending_q && cmd_i.op == utq_pkg::OP_SHIFT) begin
      due_q <= due_q + cmd_i.value;
    end
  end

  // Strict less-than keeps the lower type on equal times
  assign hit = pending_q && (!scan_i.found || (due_q < scan_i.best_time));

  always_comb begin
    scan_d.token     = scan_i.token;
    scan_d.found     = scan_i.found | pending_q;
    scan_d.best_time = hit ? due_q : scan_i.best_time;
    scan_idx_d       = hit ? IdxW'(Idx) : scan_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      scan_idx_q <= '0;
    end else begin
      scan_q     <= scan_d;
      scan_idx_q <= scan_idx_d;
    end
  end

  assign scan_o     = scan_q;
  assign scan_idx_o = scan_idx_q;

endmodule

/* rtl/unique_timed_event_queue_core.sv */
// Channel  | Handshake         | Payload
// ---------+-------------------+--------------------------------------------------
// command  | start / busy      | func_i, event_type_i, event_time_i, now_i,
//          |                   | old_base_i, new_base_i
// result   | done_o (1 cycle)  | fired_o, fired_type_o, fired_time_o,
//          |                   | queue_empty_o, next_time_o
//
// A transaction runs from accept through the launch state and the search token
// walking the row of cells, one cell per cycle, to the registered done_o; a
// rebase passes through a shift state before the launch state.
// A new command is taken in the same cycle that done_o shows a result.
// Reset clears all pending marks; the queue comes up empty and idle.
// The receiver cannot stall: done_o marks each result for one cycle only.
module unique_timed_event_queue_core #(
  parameter int EventTypes = utq_pkg::EVENT_TYPES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [utq_pkg::TYPE_W-1:0]    event_type_i,
  input  logic [utq_pkg::TIME_W-1:0]    event_time_i,
  input  logic [utq_pkg::TIME_W-1:0]    now_i,
  input  logic [utq_pkg::TIME_W-1:0]    old_base_i,
  input  logic [utq_pkg::TIME_W-1:0]    new_base_i,
  output logic                          done_o,
  output logic                          fired_o,
  output logic [utq_pkg::TYPE_W-1:0]    fired_type_o,
  output logic [utq_pkg::TIME_W-1:0]    fired_time_o,
  output logic                          queue_empty_o,
  output logic [utq_pkg::TIME_W-1:0]    next_time_o
);

  localparam int IdxW = $clog2(EventTypes);

  utq_pkg::state_e               state_q, state_d;
  logic                          accept;
  logic                          type_ok;
  logic                          poll_due;
  logic                          scan_done;

  utq_pkg::cell_cmd_t            cell_cmd;
  logic [IdxW-1:0]               sel_idx;

  utq_pkg::scan_t                scan_link [EventTypes+1];
  logic [IdxW-1:0]               idx_link  [EventTypes+1];

  logic [utq_pkg::TIME_W-1:0]    delta_q, delta_d;

  // Earliest event from the last completed search
  logic                          head_found_q;
  logic [utq_pkg::TIME_W-1:0]    head_time_q;
  logic [IdxW-1:0]               head_idx_q;

  logic                          done_q;
  logic                          fired_q;
  logic [IdxW-1:0]               fired_idx_q;
  logic [utq_pkg::TIME_W-1:0]    fired_time_q;

  assign busy      = (state_q != utq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign type_ok   = (32'(event_type_i) < EventTypes);
  assign poll_due  = head_found_q && (head_time_q <= now_i);
  assign scan_done = (state_q == utq_pkg::ST_SCAN) && scan_link[EventTypes].token;
  assign delta_d   = new_base_i - old_base_i;

  // Command decode: drive the broadcast to the cells and pick the next state
  always_comb begin
    cell_cmd.op    = utq_pkg::OP_NOP;
    cell_cmd.value = event_time_i;
    sel_idx        = IdxW'(event_type_i);
    state_d        = state_q;
    case (state_q)
      utq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = utq_pkg::ST_LAUNCH;
          case (utq_pkg::func_e'(func_i))
            utq_pkg::FUNC_ADD: begin
              if (type_ok) begin
                cell_cmd.op = utq_pkg::OP_SET;
              end
            end
            utq_pkg::FUNC_REMOVE: begin
              if (type_ok) begin
                cell_cmd.op = utq_pkg::OP_CLEAR;
              end
            end
            utq_pkg::FUNC_POLL: begin
              // pop the cached head if it is due
              sel_idx = head_idx_q;
              if (poll_due) begin
                cell_cmd.op = utq_pkg::OP_CLEAR;
              end
            end
            utq_pkg::FUNC_REBASE: begin
              state_d = utq_pkg::ST_SHIFT;
            end
            default: begin
              state_d = utq_pkg::ST_LAUNCH;
            end
          endcase
        end
      end
      utq_pkg::ST_SHIFT: begin
        // advance every pending time by new base minus old base
        cell_cmd.op    = utq_pkg::OP_SHIFT;
        cell_cmd.value = delta_q;
        state_d        = utq_pkg::ST_LAUNCH;
      end
      utq_pkg::ST_LAUNCH: begin
        state_d = utq_pkg::ST_SCAN;
      end
      utq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = utq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = utq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= utq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Search token enters cell 0 once the storage holds the updated state
  assign scan_link[0].token     = (state_q == utq_pkg::ST_LAUNCH);
  assign scan_link[0].found     = 1'b0;
  assign scan_link[0].best_time = '0;
  assign idx_link[0]            = '0;

  for (genvar k = 0; k < EventTypes; k++) begin : g_cell
    utq_cell #(
      .Idx  (k),
      .IdxW (IdxW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cell_cmd),
      .sel_idx_i  (sel_idx),
      .scan_i     (scan_link[k]),
      .scan_idx_i (idx_link[k]),
      .scan_o     (scan_link[k+1]),
      .scan_idx_o (idx_link[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      delta_q <= delta_d;
    end
  end

  // Hold the head found by the last search; it serves the next poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_found_q <= 1'b0;
      done_q       <= 1'b0;
      fired_q      <= 1'b0;
    end else begin
      done_q <= scan_done;
      if (scan_done) begin
        head_found_q <= scan_link[EventTypes].found;
      end
      if (accept) begin
        fired_q <= (utq_pkg::func_e'(func_i) == utq_pkg::FUNC_POLL) && poll_due;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      head_time_q <= scan_link[EventTypes].best_time;
      head_idx_q  <= idx_link[EventTypes];
    end
    if (accept) begin
      fired_idx_q  <= head_idx_q;
      fired_time_q <= head_time_q;
    end
  end

  assign done_o        = done_q;
  assign fired_o       = fired_q;
  assign fired_type_o  = fired_q ? utq_pkg::TYPE_W'(fired_idx_q) : '0;
  assign fired_time_o  = fired_q ? fired_time_q : '0;
  assign queue_empty_o = !head_found_q;
  assign next_time_o   = head_found_q ? head_time_q : '0;

endmodule

/* rtl/utq_checker.sv */
module utq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic                          fired_o,
  input logic [utq_pkg::TYPE_W-1:0]    fired_type_o,
  input logic [utq_pkg::TIME_W-1:0]    fired_time_o,
  input logic                          queue_empty_o,
  input logic [utq_pkg::TIME_W-1:0]    next_time_o
);

  // a result only shows once the search is over
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_no_fire_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !fired_o) |-> (fired_type_o == '0 && fired_time_o == '0))
    else $error("fired fields nonzero without a pop");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && queue_empty_o) |-> (next_time_o == '0))
    else $error("next time nonzero on empty queue");

endmodule

bind unique_timed_event_queue_core utq_checker u_utq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .fired_o       (fired_o),
  .fired_type_o  (fired_type_o),
  .fired_time_o  (fired_time_o),
  .queue_empty_o (queue_empty_o),
  .next_time_o   (next_time_o)
);

/* dv/unique_timed_event_queue_core_tb.sv */
`timescale 1ns / 1ps

module unique_timed_event_queue_core_tb;

  localparam int          EventTypes = utq_pkg::EVENT_TYPES;
  localparam int          RandItems  = 1030;
  // Slowest legal run: ~1050 transactions of rebase length plus the longest
  // driver gaps, taken several times over.
  localparam int          CycleLimit = 400000;
  localparam logic [63:0] TimeMax    = '1;

  // One command transaction as the driver presents it.
  typedef struct {
    utq_pkg::func_e func;
    logic [3:0]     etype;
    logic [63:0]    etime;
    logic [63:0]    now;
    logic [63:0]    oldb;
    logic [63:0]    newb;
    bit             drain;  // hold off until every outstanding result is back
  } sched_cmd_t;

  // One result transaction as the block reports it.
  typedef struct {
    logic        fired;
    logic [3:0]  ftype;
    logic [63:0] ftime;
    logic        empty;
    logic [63:0] next;
  } sched_res_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic [1:0]  func_i       = '0;
  logic [3:0]  event_type_i = '0;
  logic [63:0] event_time_i = '0;
  logic [63:0] now_i        = '0;
  logic [63:0] old_base_i   = '0;
  logic [63:0] new_base_i   = '0;
  logic        busy;
  logic        done_o;
  logic        fired_o;
  logic [3:0]  fired_type_o;
  logic [63:0] fired_time_o;
  logic        queue_empty_o;
  logic [63:0] next_time_o;

  unique_timed_event_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .event_type_i  (event_type_i),
    .event_time_i  (event_time_i),
    .now_i         (now_i),
    .old_base_i    (old_base_i),
    .new_base_i    (new_base_i),
    .done_o        (done_o),
    .fired_o       (fired_o),
    .fired_type_o  (fired_type_o),
    .fired_time_o  (fired_time_o),
    .queue_empty_o (queue_empty_o),
    .next_time_o   (next_time_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Shadow copy of the scheduler state.
  logic        sched_pending [EventTypes];
  logic [63:0] sched_due     [EventTypes];

  sched_cmd_t  cmd_q[$];      // command transactions not yet presented
  sched_res_t  outcome_q[$];  // predicted results, oldest first
  sched_cmd_t  cur_cmd;
  int          errors    = 0;
  int          gap_left  = 0;
  int          burst_left = 0;
  int          cycle_cnt = 0;
  bit          nxt_start;
  sched_res_t  got, want;

  // Lowest type wins among equal due times, hence the strict compare.
  function automatic int earliest_slot();
    int best = -1;
    for (int k = 0; k < EventTypes; k++) begin
      if (sched_pending[k] && (best < 0 || sched_due[k] < sched_due[best])) best = k;
    end
    return best;
  endfunction

  // Advance the shadow state by one command and return the result it causes.
  function automatic sched_res_t apply_command(sched_cmd_t c);
    sched_res_t r = '{default: '0};
    int         head;
    case (c.func)
      utq_pkg::FUNC_ADD: begin
        if (c.etype < EventTypes) begin
          sched_pending[c.etype] = 1'b1;
          sched_due[c.etype]     = c.etime;
        end
      end
      utq_pkg::FUNC_REMOVE: begin
        if (c.etype < EventTypes) sched_pending[c.etype] = 1'b0;
      end
      utq_pkg::FUNC_POLL: begin
        head = earliest_slot();
        if (head >= 0 && sched_due[head] <= c.now) begin
          r.fired             = 1'b1;
          r.ftype             = head[3:0];
          r.ftime             = sched_due[head];
          sched_pending[head] = 1'b0;
        end
      end
      default: begin
        // Rebase wraps modulo 2^64 by the width of the vectors.
        for (int k = 0; k < EventTypes; k++) begin
          if (sched_pending[k]) sched_due[k] = sched_due[k] - c.oldb + c.newb;
        end
      end
    endcase
    head    = earliest_slot();
    r.empty = (head < 0);
    r.next  = (head < 0) ? 64'd0 : sched_due[head];
    return r;
  endfunction

  // Mostly back-to-back, often a gap that lands somewhere inside the busy
  // window, now and then a long pause; sometimes a stretch with no gaps at all.
  function automatic int pick_gap();
    int roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, EventTypes + 4);
    if (roll < 97) return $urandom_range(1, 8);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queue one command; unused fields carry random bits so every pin toggles.
  task automatic push_cmd(utq_pkg::func_e f, logic [3:0] ty, logic [63:0] et,
                          logic [63:0] nw, logic [63:0] ob, logic [63:0] nb,
                          bit drain = 1'b0);
    sched_cmd_t c;
    c.func  = f;
    c.etype = ty;
    c.etime = et;
    c.now   = nw;
    c.oldb  = ob;
    c.newb  = nb;
    c.drain = drain;
    cmd_q = {cmd_q, c};
  endtask

  // Driver: present the next command once the gap has run out.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      nxt_start = start;
      if (start && !busy) begin
        // Transaction accepted at this edge: predict it now, in accept order.
        outcome_q = {outcome_q, apply_command(cur_cmd)};
        nxt_start = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          gap_left = pick_gap();
          if ($urandom_range(0, 99) < 4) burst_left = $urandom_range(10, 40);
        end
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && outcome_q.size() != 0)) begin
          cur_cmd      = cmd_q.pop_front();
          func_i       <= cur_cmd.func;
          event_type_i <= cur_cmd.etype;
          event_time_i <= cur_cmd.etime;
          now_i        <= cur_cmd.now;
          old_base_i   <= cur_cmd.oldb;
          new_base_i   <= cur_cmd.newb;
          nxt_start    = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: every done_o pulse is one result transaction; match it against
  // the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      got = '{fired_o, fired_type_o, fired_time_o, queue_empty_o, next_time_o};
      if (outcome_q.size() == 0) begin
        $display("%0t: result with none expected: fired %0b type %0d time %0h",
                 $time, got.fired, got.ftype, got.ftime);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (got.fired !== want.fired) begin
          $display("%0t: fired expected %0b actual %0b", $time, want.fired, got.fired);
          errors++;
        end
        if (got.ftype !== want.ftype) begin
          $display("%0t: fired_type expected %0d actual %0d", $time, want.ftype, got.ftype);
          errors++;
        end
        if (got.ftime !== want.ftime) begin
          $display("%0t: fired_time expected %h actual %h", $time, want.ftime, got.ftime);
          errors++;
        end
        if (got.empty !== want.empty) begin
          $display("%0t: queue_empty expected %0b actual %0b", $time, want.empty, got.empty);
          errors++;
        end
        if (got.next !== want.next) begin
          $display("%0t: next_time expected %h actual %h", $time, want.next, got.next);
          errors++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
      $display("unique_timed_event_queue_core_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] base;
    int          n;
    int          cnt;
    int          roll;

    for (int k = 0; k < EventTypes; k++) begin
      sched_pending[k] = 1'b0;
      sched_due[k]     = '0;
    end

    // Directed part: extremes, ties, replace, stale remove, wrap on rebase.
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), 64'd0,   rand64(), rand64()); // empty poll
    push_cmd(utq_pkg::FUNC_REBASE, 4'd6,  rand64(), rand64(), TimeMax, 64'd0);  // rebase empty
    push_cmd(utq_pkg::FUNC_REMOVE, 4'd7,  rand64(), rand64(), rand64(), rand64()); // not pending
    push_cmd(utq_pkg::FUNC_ADD,    4'd0,  64'd0,    rand64(), rand64(), rand64());
    push_cmd(utq_pkg::FUNC_ADD,    4'd15, TimeMax,  rand64(), rand64(), rand64());
    push_cmd(utq_pkg::FUNC_POLL,   4'd2,  rand64(), 64'd0,   rand64(), rand64()); // fires type 0
    push_cmd(utq_pkg::FUNC_POLL,   4'd2,  rand64(), TimeMax - 1, rand64(), rand64()); // not due
    push_cmd(utq_pkg::FUNC_POLL,   4'd2,  rand64(), TimeMax, rand64(), rand64()); // fires 15
    push_cmd(utq_pkg::FUNC_ADD,    4'd5,  64'd100,  rand64(), rand64(), rand64());
    push_cmd(utq_pkg::FUNC_ADD,    4'd3,  64'd100,  rand64(), rand64(), rand64()); // tie with 5
    push_cmd(utq_pkg::FUNC_ADD,    4'd9,  64'd50,   rand64(), rand64(), rand64());
    push_cmd(utq_pkg::FUNC_ADD,    4'd9,  64'd200,  rand64(), rand64(), rand64()); // replace
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), 64'd99,  rand64(), rand64()); // nothing due
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), 64'd100, rand64(), rand64()); // tie: type 3
    push_cmd(utq_pkg::FUNC_REMOVE, 4'd5,  rand64(), rand64(), rand64(), rand64());
    push_cmd(utq_pkg::FUNC_REMOVE, 4'd5,  rand64(), rand64(), rand64(), rand64()); // again
    push_cmd(utq_pkg::FUNC_REBASE, 4'd0,  rand64(), rand64(), 64'd300, 64'd10);  // wraps low
    push_cmd(utq_pkg::FUNC_ADD,    4'd1,  64'd5,    rand64(), rand64(), rand64(), 1'b1);
    push_cmd(utq_pkg::FUNC_REBASE, 4'd0,  rand64(), rand64(), 64'd0,   TimeMax); // wraps high
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), TimeMax, rand64(), rand64());
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), TimeMax, rand64(), rand64());
    push_cmd(utq_pkg::FUNC_POLL,   4'd0,  rand64(), TimeMax, rand64(), rand64()); // empty again

    // Random part: traffic clustered around a moving time base so that polls
    // fire and ties occur, with fill and drain episodes and some pure noise.
    base = rand64();
    n    = 0;
    while (n < RandItems) begin
      roll = $urandom_range(0, 9);
      if (roll <= 5) begin
        cnt = $urandom_range(0, 99);
        if (cnt < 40) begin
          push_cmd(utq_pkg::FUNC_ADD, 4'($urandom_range(0, 15)),
                   ($urandom_range(0, 9) == 0) ? rand64() : base + $urandom_range(0, 200),
                   rand64(), rand64(), rand64(), ($urandom_range(0, 99) == 0));
        end else if (cnt < 55) begin
          push_cmd(utq_pkg::FUNC_REMOVE, 4'($urandom_range(0, 15)), rand64(), rand64(),
                   rand64(), rand64());
        end else if (cnt < 90) begin
          push_cmd(utq_pkg::FUNC_POLL, 4'($urandom_range(0, 15)), rand64(),
                   ($urandom_range(0, 9) == 0) ? rand64() : base + $urandom_range(0, 250),
                   rand64(), rand64());
        end else begin
          push_cmd(utq_pkg::FUNC_REBASE, 4'($urandom_range(0, 15)), rand64(), rand64(),
                   base, base + $urandom_range(0, 64));
        end
        n++;
      end else if (roll == 6) begin
        // Fill: many adds, duplicates and ties likely.
        cnt = $urandom_range(6, EventTypes);
        repeat (cnt) begin
          push_cmd(utq_pkg::FUNC_ADD, 4'($urandom_range(0, 15)),
                   base + $urandom_range(0, 40), rand64(), rand64(), rand64());
        end
        n += cnt;
      end else if (roll == 7) begin
        // Drain: polls far enough ahead that everything is due.
        cnt = $urandom_range(4, EventTypes + 1);
        repeat (cnt) begin
          push_cmd(utq_pkg::FUNC_POLL, 4'($urandom_range(0, 15)), rand64(),
                   base + $urandom_range(200, 1000), rand64(), rand64());
        end
        base = base + $urandom_range(0, 300);
        n += cnt;
      end else if (roll == 8) begin
        // Well-formed rebase: move the base, sometimes next to the wrap point.
        logic [63:0] nb;
        nb = ($urandom_range(0, 3) == 0) ? TimeMax - $urandom_range(0, 100) : rand64();
        push_cmd(utq_pkg::FUNC_REBASE, 4'($urandom_range(0, 15)), rand64(), rand64(),
                 base, nb, ($urandom_range(0, 19) == 0));
        base = nb;
        n++;
      end else begin
        push_cmd(utq_pkg::func_e'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                 rand64(), rand64(), rand64(), rand64());
        n++;
      end
    end

    // Hold reset low from time zero, then release it at a clock edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to be accepted and answered, then let the
    // block settle so a stray extra result would still be caught.
    while (cmd_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk_i);
    repeat (EventTypes + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("unique_timed_event_queue_core_tb: clean");
    end else begin
      $display("unique_timed_event_queue_core_tb: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/utq_pkg.sv
rtl/utq_cell.sv
rtl/unique_timed_event_queue_core.sv
rtl/utq_checker.sv
dv/unique_timed_event_queue_core_tb.sv
